@@ hw/rtl/pqnp_pkg.sv @@
`default_nettype none

package pqnp_pkg;

    localparam int unsigned BYTES_PER_SIDE  = 131072;
    localparam int unsigned PALETTE_ENTRIES = 6;
    localparam int unsigned MAX_COLUMNS     = 2048;

    localparam int unsigned NIB_CNT_W = $clog2(2 * BYTES_PER_SIDE);
    localparam int unsigned ADDR_W    = 17;
    localparam int unsigned COL_W     = 11;
    localparam int unsigned COLCNT_W  = 12;
    localparam int unsigned COLOR_W   = 24;
    localparam int unsigned DIST_W    = 18;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [NIB_CNT_W:0]   NIB_LIMIT = (NIB_CNT_W + 1)'(2 * BYTES_PER_SIDE);
    localparam logic [NIB_CNT_W-1:0] NIB_WRAP  = NIB_CNT_W'(2 * BYTES_PER_SIDE - 2);

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_5      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd7;

    localparam logic [2:0]          PALETTE_SIZE_RESET = 3'd6;
    localparam logic [COLCNT_W-1:0] COLUMN_COUNT_RESET = 12'd480;

    typedef struct packed {
        logic              side;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        byte_value;
        logic              last_of_run;
    } result_t;

    // palette index to display code: 0,1,2,3,5,6
    function automatic logic [2:0] display_code(input logic [IDX_W-1:0] idx);
        logic [2:0] code;
        case (idx)
            3'd4:    code = 3'd5;
            3'd5:    code = 3'd6;
            3'd0, 3'd1, 3'd2, 3'd3: code = idx;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    function automatic logic [DIST_W-1:0] sq_dist(input logic [7:0]         r,
                                                  input logic [7:0]         g,
                                                  input logic [7:0]         b,
                                                  input logic [COLOR_W-1:0] c);
        logic [7:0]  dr, dg, db;
        logic [15:0] sr, sg, sb;
        dr = (r > c[23:16]) ? r - c[23:16] : c[23:16] - r;
        dg = (g > c[15:8])  ? g - c[15:8]  : c[15:8]  - g;
        db = (b > c[7:0])   ? b - c[7:0]   : c[7:0]   - b;
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        return {2'b00, sr} + {2'b00, sg} + {2'b00, sb};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/palette_quantize_nibble_pack.sv @@
// A pixel goes through the pixel and distance registers and the queue before m_*.
// Throughput: one pixel per cycle while the result queue has room for two results;
//   an end-of-frame pixel that flushes may write two results into the four-entry queue.
// Stages: pixel register, squared-distance register, pick/pack into the result queue.
// Reset clears the pipeline, the queue and the packing counters, and sets the
//   palette to zero, palette_size to 6 and column_count to 480.
`default_nettype none

module palette_quantize_nibble_pack (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_we,
    input  wire logic [pqnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pqnp_pkg::COLOR_W-1:0]      cfg_data,

    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic [7:0]                        s_red,
    input  wire logic [7:0]                        s_green,
    input  wire logic [7:0]                        s_blue,
    input  wire logic                              s_end_of_frame,

    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic                              m_side,
    output      logic [pqnp_pkg::ADDR_W-1:0]       m_byte_address,
    output      logic [7:0]                        m_byte_value,
    output      logic                              m_last_of_run
);

    localparam int unsigned NE   = pqnp_pkg::PALETTE_ENTRIES;
    localparam int unsigned NCW  = pqnp_pkg::NIB_CNT_W;
    localparam int unsigned AW   = pqnp_pkg::ADDR_W;
    localparam int unsigned CW   = pqnp_pkg::COL_W;
    localparam int unsigned CCW  = pqnp_pkg::COLCNT_W;
    localparam int unsigned DW   = pqnp_pkg::DIST_W;
    localparam int unsigned IW   = pqnp_pkg::IDX_W;
    localparam int unsigned PW   = pqnp_pkg::FIFO_PTR_W;
    localparam int unsigned FCW  = pqnp_pkg::FIFO_CNT_W;

    // configuration
    logic [pqnp_pkg::COLOR_W-1:0] palette_reg [NE];
    logic [2:0]                   palette_size_reg;
    logic [CCW-1:0]               column_count_reg;

    // pipeline
    logic          s1_valid_reg;
    logic [7:0]    s1_red_reg, s1_green_reg, s1_blue_reg;
    logic          s1_eof_reg;
    logic          s2_valid_reg;
    logic [DW-1:0] s2_dist_reg [NE];
    logic          s2_eof_reg;
    logic          s1_ready, s2_ready, s2_fire;

    // packing state
    logic [CW-1:0]  col_pos_reg, col_pos_next;
    logic [NCW-1:0] left_cnt_reg, right_cnt_reg, left_cnt_next, right_cnt_next;
    logic [2:0]     left_pend_reg, right_pend_reg, left_pend_next, right_pend_next;

    // result queue
    pqnp_pkg::result_t fifo_reg [pqnp_pkg::FIFO_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [FCW-1:0]    fifo_cnt_reg;
    logic              pop;

    // selection and packing
    logic [2:0]              n_search;
    logic [NE-1:0]           entry_en;
    logic [DW-1:0]           best_d;
    logic [IW-1:0]           win_idx;
    logic [2:0]              code;
    logic [CCW-1:0]          cols;
    logic                    go_left;
    logic [CCW-1:0]          col_inc;
    logic [NCW-1:0]          sel_cnt, cnt_upd;
    logic [NCW:0]            cnt_inc;
    logic [2:0]              sel_pend, pend_upd;
    logic [NCW-1:0]          left_cnt_after, right_cnt_after;
    logic [2:0]              left_pend_after, right_pend_after;
    logic                    c0_v, c1_v, c2_v;
    pqnp_pkg::result_t       c0, c1, c2, slot0, slot1;
    logic [1:0]              n_res;

    assign s2_fire  = s2_valid_reg && (fifo_cnt_reg <= FCW'(pqnp_pkg::FIFO_DEPTH - 2));
    assign s2_ready = !s2_valid_reg || s2_fire;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    // nearest enabled entry, lowest index on a tie
    always_comb begin
        n_search = (palette_size_reg > 3'(NE)) ? 3'(NE) : palette_size_reg;
        best_d   = '1;
        win_idx  = '0;
        for (int i = 0; i < NE; i++) begin
            entry_en[i] = 3'(i) < n_search;
            if (entry_en[i] && (s2_dist_reg[i] < best_d)) begin
                best_d  = s2_dist_reg[i];
                win_idx = IW'(i);
            end
        end
        code = pqnp_pkg::display_code(win_idx);
    end

    always_comb begin
        cols = (column_count_reg > CCW'(pqnp_pkg::MAX_COLUMNS))
             ? CCW'(pqnp_pkg::MAX_COLUMNS) : column_count_reg;
        go_left = col_pos_reg < cols[CCW-1:1];
        col_inc = {1'b0, col_pos_reg} + CCW'(1);

        sel_cnt  = go_left ? left_cnt_reg  : right_cnt_reg;
        sel_pend = go_left ? left_pend_reg : right_pend_reg;
        cnt_inc  = {1'b0, sel_cnt} + (NCW + 1)'(1);
        // hold at the last byte once the buffer is full
        cnt_upd  = (cnt_inc >= pqnp_pkg::NIB_LIMIT) ? pqnp_pkg::NIB_WRAP : cnt_inc[NCW-1:0];
        pend_upd = sel_cnt[0] ? sel_pend : code;

        left_cnt_after   = go_left ? cnt_upd  : left_cnt_reg;
        left_pend_after  = go_left ? pend_upd : left_pend_reg;
        right_cnt_after  = go_left ? right_cnt_reg  : cnt_upd;
        right_pend_after = go_left ? right_pend_reg : pend_upd;

        c0_v = sel_cnt[0];
        c0.side         = !go_left;
        c0.byte_address = AW'(sel_cnt >> 1);
        c0.byte_value   = {1'b0, sel_pend, 1'b0, code};
        c0.last_of_run  = 1'b0;

        c1_v = s2_eof_reg && left_cnt_after[0];
        c1.side         = 1'b0;
        c1.byte_address = AW'(left_cnt_after >> 1);
        c1.byte_value   = {1'b0, left_pend_after, 4'h0};
        c1.last_of_run  = 1'b0;

        c2_v = s2_eof_reg && right_cnt_after[0];
        c2.side         = 1'b1;
        c2.byte_address = AW'(right_cnt_after >> 1);
        c2.byte_value   = {1'b0, right_pend_after, 4'h0};
        c2.last_of_run  = 1'b0;

        // pack the valid candidates in order into two slots
        slot0 = c0_v ? c0 : (c1_v ? c1 : c2);
        slot1 = c0_v ? (c1_v ? c1 : c2) : c2;
        n_res = {1'b0, c0_v} + {1'b0, c1_v} + {1'b0, c2_v};
        if (n_res == 2'd1) begin
            slot0.last_of_run = 1'b1;
        end
        if (n_res == 2'd2) begin
            slot1.last_of_run = 1'b1;
        end

        if (s2_eof_reg) begin
            col_pos_next    = '0;
            left_cnt_next   = '0;
            right_cnt_next  = '0;
            left_pend_next  = '0;
            right_pend_next = '0;
        end else begin
            col_pos_next    = (col_inc >= cols) ? '0 : col_inc[CW-1:0];
            left_cnt_next   = left_cnt_after;
            right_cnt_next  = right_cnt_after;
            left_pend_next  = left_pend_after;
            right_pend_next = right_pend_after;
        end
    end

    assign pop            = m_valid && m_ready;
    assign m_valid        = fifo_cnt_reg != '0;
    assign m_side         = fifo_reg[rd_ptr_reg].side;
    assign m_byte_address = fifo_reg[rd_ptr_reg].byte_address;
    assign m_byte_value   = fifo_reg[rd_ptr_reg].byte_value;
    assign m_last_of_run  = fifo_reg[rd_ptr_reg].last_of_run;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NE; i++) begin
                palette_reg[i] <= '0;
            end
            palette_size_reg <= pqnp_pkg::PALETTE_SIZE_RESET;
            column_count_reg <= pqnp_pkg::COLUMN_COUNT_RESET;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            col_pos_reg      <= '0;
            left_cnt_reg     <= '0;
            right_cnt_reg    <= '0;
            left_pend_reg    <= '0;
            right_pend_reg   <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fifo_cnt_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index) inside
                    [pqnp_pkg::REG_COLOR_0:pqnp_pkg::REG_COLOR_5]:
                        palette_reg[cfg_index] <= cfg_data;
                    pqnp_pkg::REG_PALETTE_SIZE: palette_size_reg <= cfg_data[2:0];
                    pqnp_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data[CCW-1:0];
                    default: ;
                endcase
            end
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_fire) begin
                col_pos_reg    <= col_pos_next;
                left_cnt_reg   <= left_cnt_next;
                right_cnt_reg  <= right_cnt_next;
                left_pend_reg  <= left_pend_next;
                right_pend_reg <= right_pend_next;
                wr_ptr_reg     <= wr_ptr_reg + PW'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + (s2_fire ? FCW'(n_res) : FCW'(0))
                          - (pop ? FCW'(1) : FCW'(0));
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s1_ready) begin
            s1_red_reg   <= s_red;
            s1_green_reg <= s_green;
            s1_blue_reg  <= s_blue;
            s1_eof_reg   <= s_end_of_frame;
        end
        if (s1_valid_reg && s2_ready) begin
            for (int i = 0; i < NE; i++) begin
                s2_dist_reg[i] <= pqnp_pkg::sq_dist(s1_red_reg, s1_green_reg, s1_blue_reg,
                                                    palette_reg[i]);
            end
            s2_eof_reg <= s1_eof_reg;
        end
        if (s2_fire) begin
            if (n_res != 2'd0) begin
                fifo_reg[wr_ptr_reg] <= slot0;
            end
            if (n_res == 2'd2) begin
                fifo_reg[wr_ptr_reg + PW'(1)] <= slot1;
            end
        end
    end

endmodule

`default_nettype wire
